FILE: src/fmp_pkg.sv
// Shared types, constants and helpers of the Fibonacci matrix power unit.
`default_nettype none
package fmp_pkg;

  // Field widths and default index width.
  localparam int IDX_W          = 32;
  localparam int VAL_W          = 30;
  localparam int INDEX_BITS_DEF = 32;

  // The prime modulus and values derived from it.
  localparam logic [VAL_W-1:0] P_MOD    = 30'd1000000007;
  localparam logic [31:0]      P_MOD32  = 32'd1000000007;
  localparam logic [31:0]      P_MOD2X  = 32'd2000000014;
  localparam logic [VAL_W-1:0] P_MINUS1 = 30'd1000000006;

  // Barrett reciprocal: floor(2^60 / p), which fits in 31 bits.
  localparam logic [63:0] MU_WIDE    = 64'h1000_0000_0000_0000 / 64'd1000000007;
  localparam logic [30:0] BARRETT_MU = 31'(MU_WIDE);

  // Cycles from issuing a product to its landing in the product file.
  localparam int MM_LAT = 6;

  // Product tags: bit 3 picks the matrix product (accumulator times base or
  // base squared), bits 2:1 pick the entry, bit 0 picks the partial term.
  localparam logic [3:0] TAG_ACC_FIRST = 4'd0;
  localparam logic [3:0] TAG_SQR_FIRST = 4'd8;
  localparam logic [3:0] TAG_LAST      = 4'd15;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ISSUE,
    ST_DRAIN,
    ST_COMBINE,
    ST_FINAL
  } fmp_state_t;

  typedef struct packed {
    logic       load;
    logic       issue;
    logic [3:0] tag;
    logic       combine;
    logic       finish;
  } fmp_cmd_t;

  typedef struct packed {
    logic k_zero;
    logic k_bit0;
  } fmp_sts_t;

  // Sum of two residues, reduced once.
  function automatic logic [VAL_W-1:0] add_mod(input logic [VAL_W-1:0] a,
                                               input logic [VAL_W-1:0] b);
    logic [VAL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, P_MOD}) begin
      return VAL_W'(s - {1'b0, P_MOD});
    end
    return s[VAL_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: src/fibonacci_matrix_power_mod_unit.sv
// Top level of the Fibonacci matrix power unit modulo 1000000007.
`default_nettype none
// Usage: drive in_index and raise start; the item is taken at the rising edge
// where start is high and busy is low. The unit then raises the matrix
// [[0,1],[1,1]] to the power n by square-and-multiply, from the least
// significant exponent bit up, and stops as soon as no set bit remains.
// Only the low INDEX_BITS bits of in_index are used.
// The result item, F(n) and F(0)+...+F(n) both modulo the prime, appears on
// out_fib_value and out_prefix_sum for exactly one cycle with out_strobe high.
// The receiver cannot stall, so it must take the item in that cycle.
// Each exponent bit issues sixteen modular products (eight when the bit is
// clear) into the one five-stage multiplier pipeline, waits for it to
// drain, and then combines the partial products and tests the next bit.
// One item is in flight at a time; busy is high from acceptance until the
// cycle before the strobe, so the next start can be taken in the strobe cycle.
// Reset (rst_n low, synchronous) returns the controller to idle and clears
// the strobe and pipeline valid bits; no result is produced for an item
// that was in flight.
module fibonacci_matrix_power_mod_unit #(
  parameter int INDEX_BITS = fmp_pkg::INDEX_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [fmp_pkg::IDX_W-1:0] in_index,
  output logic                           out_strobe,
  output logic [fmp_pkg::VAL_W-1:0]      out_fib_value,
  output logic [fmp_pkg::VAL_W-1:0]      out_prefix_sum
);

  fmp_pkg::fmp_cmd_t cmd;
  fmp_pkg::fmp_sts_t sts;

  // The controller owns sequencing only; all arithmetic sits in the datapath.
  fmp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  fmp_datapath #(
    .INDEX_BITS (INDEX_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_index       (in_index),
    .out_strobe     (out_strobe),
    .out_fib_value  (out_fib_value),
    .out_prefix_sum (out_prefix_sum)
  );

  // An accepted item always makes the unit busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("unit not busy after accepting an item");

  // The strobe is raised only once the controller is back in idle.
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result strobe while busy");

  // Each result lasts exactly one cycle.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held longer than one cycle");

  // Both results are fully reduced residues.
  a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ((out_fib_value < fmp_pkg::P_MOD) &&
                    (out_prefix_sum < fmp_pkg::P_MOD)))
    else $error("result not reduced modulo the prime");

endmodule
`default_nettype wire

FILE: src/fmp_mulmod.sv
// Pipelined modular multiplier with Barrett reduction by the prime modulus.
`default_nettype none
module fmp_mulmod (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_vld,
  input  wire logic [3:0]                in_tag,
  input  wire logic [fmp_pkg::VAL_W-1:0] in_a,
  input  wire logic [fmp_pkg::VAL_W-1:0] in_b,
  output logic                           res_vld,
  output logic [3:0]                     res_tag,
  output logic [fmp_pkg::VAL_W-1:0]      res_val
);

  logic [4:0]  vld_r;
  logic [3:0]  tag1_r, tag2_r, tag3_r, tag4_r, tag5_r;
  logic [59:0] prod_r;
  logic [30:0] q_r;
  logic [31:0] xlo2_r, xlo3_r;
  logic [31:0] qp_r;
  logic [31:0] rem_r;
  logic [fmp_pkg::VAL_W-1:0] res_r;

  logic [61:0] qmul;
  logic [60:0] qp_full;
  logic [31:0] rem_fix;

  assign qmul    = 62'(prod_r[59:29]) * 62'(fmp_pkg::BARRETT_MU);
  assign qp_full = 61'(q_r) * 61'(fmp_pkg::P_MOD);

  // The Barrett estimate is short by at most two multiples of the modulus.
  always_comb begin
    if (rem_r >= fmp_pkg::P_MOD2X) begin
      rem_fix = rem_r - fmp_pkg::P_MOD2X;
    end else if (rem_r >= fmp_pkg::P_MOD32) begin
      rem_fix = rem_r - fmp_pkg::P_MOD32;
    end else begin
      rem_fix = rem_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[3:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    tag1_r <= in_tag;
    prod_r <= 60'(in_a) * 60'(in_b);
    tag2_r <= tag1_r;
    q_r    <= qmul[61:31];
    xlo2_r <= prod_r[31:0];
    tag3_r <= tag2_r;
    qp_r   <= qp_full[31:0];
    xlo3_r <= xlo2_r;
    tag4_r <= tag3_r;
    rem_r  <= xlo3_r - qp_r;
    tag5_r <= tag4_r;
    res_r  <= rem_fix[fmp_pkg::VAL_W-1:0];
  end

  assign res_vld = vld_r[4];
  assign res_tag = tag5_r;
  assign res_val = res_r;

endmodule
`default_nettype wire

FILE: src/fmp_datapath.sv
// Datapath: exponent register, matrices, product file and result registers.
`default_nettype none
module fmp_datapath #(
  parameter int INDEX_BITS = fmp_pkg::INDEX_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire fmp_pkg::fmp_cmd_t         cmd,
  output fmp_pkg::fmp_sts_t              sts,
  input  wire logic [fmp_pkg::IDX_W-1:0] in_index,
  output logic                           out_strobe,
  output logic [fmp_pkg::VAL_W-1:0]      out_fib_value,
  output logic [fmp_pkg::VAL_W-1:0]      out_prefix_sum
);

  localparam int K_BITS = (INDEX_BITS < fmp_pkg::IDX_W) ? INDEX_BITS : fmp_pkg::IDX_W;

  logic [K_BITS-1:0]          k_r;
  logic [fmp_pkg::VAL_W-1:0]  acc_r  [0:1][0:1];
  logic [fmp_pkg::VAL_W-1:0]  base_r [0:1][0:1];
  logic [fmp_pkg::VAL_W-1:0]  pr_r   [0:15];
  logic [fmp_pkg::VAL_W-1:0]  acc_nxt  [0:1][0:1];
  logic [fmp_pkg::VAL_W-1:0]  base_nxt [0:1][0:1];
  logic                       strobe_r;
  logic [fmp_pkg::VAL_W-1:0]  fib_r, pre_r;

  logic                       op_i, op_j, op_m;
  logic [fmp_pkg::VAL_W-1:0]  op_a, op_b;
  logic                       mm_vld;
  logic [3:0]                 mm_tag;
  logic [fmp_pkg::VAL_W-1:0]  mm_val;
  logic [fmp_pkg::VAL_W-1:0]  fn2, pre_val;

  assign sts.k_zero = (k_r == {K_BITS{1'b0}});
  assign sts.k_bit0 = k_r[0];

  // Operand selection: entry (i,j) of X*Y takes X[i][m] * Y[m][j].
  assign op_i = cmd.tag[2];
  assign op_j = cmd.tag[1];
  assign op_m = cmd.tag[0];
  assign op_a = cmd.tag[3] ? base_r[op_i][op_m] : acc_r[op_i][op_m];
  assign op_b = base_r[op_m][op_j];

  fmp_mulmod u_mulmod (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (cmd.issue),
    .in_tag  (cmd.tag),
    .in_a    (op_a),
    .in_b    (op_b),
    .res_vld (mm_vld),
    .res_tag (mm_tag),
    .res_val (mm_val)
  );

  for (genvar gi = 0; gi < 2; gi++) begin : g_row
    for (genvar gj = 0; gj < 2; gj++) begin : g_col
      assign acc_nxt[gi][gj]  = fmp_pkg::add_mod(pr_r[gi*4 + gj*2],
                                                 pr_r[gi*4 + gj*2 + 1]);
      assign base_nxt[gi][gj] = fmp_pkg::add_mod(pr_r[8 + gi*4 + gj*2],
                                                 pr_r[8 + gi*4 + gj*2 + 1]);
    end
  end

  // F(n+2) = F(n) + F(n+1); the prefix sum is one less, wrapping at zero.
  assign fn2     = fmp_pkg::add_mod(acc_r[0][1], acc_r[1][1]);
  assign pre_val = (fn2 == '0) ? fmp_pkg::P_MINUS1 : (fn2 - 30'd1);

  always_ff @(posedge clk) begin
    if (mm_vld) begin
      pr_r[mm_tag] <= mm_val;
    end
    if (cmd.load) begin
      k_r          <= in_index[K_BITS-1:0];
      acc_r[0][0]  <= 30'd1;
      acc_r[0][1]  <= 30'd0;
      acc_r[1][0]  <= 30'd0;
      acc_r[1][1]  <= 30'd1;
      base_r[0][0] <= 30'd0;
      base_r[0][1] <= 30'd1;
      base_r[1][0] <= 30'd1;
      base_r[1][1] <= 30'd1;
    end else if (cmd.combine) begin
      k_r    <= k_r >> 1;
      base_r <= base_nxt;
      if (k_r[0]) begin
        acc_r <= acc_nxt;
      end
    end
    if (cmd.finish) begin
      fib_r <= acc_r[0][1];
      pre_r <= pre_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= cmd.finish;
    end
  end

  assign out_strobe     = strobe_r;
  assign out_fib_value  = fib_r;
  assign out_prefix_sum = pre_r;

endmodule
`default_nettype wire

FILE: src/fmp_ctrl.sv
// Controller: sequences bits, product issue, pipeline drain and combine.
`default_nettype none
module fmp_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire fmp_pkg::fmp_sts_t sts,
  output fmp_pkg::fmp_cmd_t      cmd
);

  localparam int DW = $clog2(fmp_pkg::MM_LAT);
  localparam logic [DW-1:0] DRAIN_LAST = DW'(fmp_pkg::MM_LAT - 2);

  fmp_pkg::fmp_state_t state_r, state_nxt;
  logic [3:0]          tag_r, tag_nxt;
  logic [DW-1:0]       cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fmp_pkg::ST_IDLE;
      tag_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      tag_r   <= tag_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    tag_nxt     = tag_r;
    cnt_nxt     = cnt_r;
    cmd.load    = 1'b0;
    cmd.issue   = 1'b0;
    cmd.tag     = tag_r;
    cmd.combine = 1'b0;
    cmd.finish  = 1'b0;
    busy        = 1'b1;
    case (state_r)
      fmp_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = fmp_pkg::ST_CHECK;
        end
      end
      fmp_pkg::ST_CHECK: begin
        if (sts.k_zero) begin
          state_nxt = fmp_pkg::ST_FINAL;
        end else begin
          tag_nxt   = sts.k_bit0 ? fmp_pkg::TAG_ACC_FIRST : fmp_pkg::TAG_SQR_FIRST;
          state_nxt = fmp_pkg::ST_ISSUE;
        end
      end
      fmp_pkg::ST_ISSUE: begin
        cmd.issue = 1'b1;
        if (tag_r == fmp_pkg::TAG_LAST) begin
          cnt_nxt   = '0;
          state_nxt = fmp_pkg::ST_DRAIN;
        end else begin
          tag_nxt = tag_r + 4'd1;
        end
      end
      fmp_pkg::ST_DRAIN: begin
        if (cnt_r == DRAIN_LAST) begin
          state_nxt = fmp_pkg::ST_COMBINE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      fmp_pkg::ST_COMBINE: begin
        cmd.combine = 1'b1;
        state_nxt   = fmp_pkg::ST_CHECK;
      end
      fmp_pkg::ST_FINAL: begin
        cmd.finish = 1'b1;
        state_nxt  = fmp_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = fmp_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: tb/sv/tb_fibonacci_matrix_power_mod_unit.sv
// Self-checking testbench for the Fibonacci matrix power unit modulo 1000000007.
`timescale 1ns / 100ps
module tb_fibonacci_matrix_power_mod_unit;

  localparam int IDX_W = fmp_pkg::IDX_W;
  localparam int VAL_W = fmp_pkg::VAL_W;
  localparam int INDEX_BITS = fmp_pkg::INDEX_BITS_DEF;

  // The prime and the first index past zero where F(n) is 0 mod the prime.
  // Since the prime is 2 mod 5, F(p+1) is 0 and the Pisano period divides 2(p+1).
  localparam logic [63:0] PRIME = 64'd1000000007;
  localparam logic [IDX_W-1:0] ZERO_STEP = 32'd1000000008;

  // The final wait outlasts the slowest item; the limit allows many times the slowest run.
  localparam int MAX_LATENCY = 760;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int RANDOM_ITEMS = 500;
  localparam int N_DIRECTED = 16;

  // One pending result, tagged with the index that produced it.
  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic [VAL_W-1:0] fib_value;
    logic [VAL_W-1:0] prefix_sum;
  } fib_expect_t;

  // One directed row; when typed is set the result is given in the row itself.
  typedef struct packed {
    logic [IDX_W-1:0] index;
    bit               typed;
    logic [VAL_W-1:0] fib_value;
    logic [VAL_W-1:0] prefix_sum;
  } index_row_t;

  // 2x2 matrix, entries 0..3 are e00, e01, e10, e11.
  typedef logic [3:0][63:0] mat2_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic [IDX_W-1:0] in_index = '0;
  logic             busy;
  logic             out_strobe;
  logic [VAL_W-1:0] out_fib_value;
  logic [VAL_W-1:0] out_prefix_sum;

  fib_expect_t pending_fibs[$];
  int unsigned items_sent = 0;
  int unsigned results_checked = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  // Directed items: the ends of the index range, single and alternating bit
  // patterns, the first index whose value wraps past the prime, and the
  // indices where the value or the prefix sum lands on a zero residue.
  index_row_t directed_rows [N_DIRECTED] = '{
    '{32'd0,          1'b1, 30'd0,          30'd0},
    '{32'd1,          1'b1, 30'd1,          30'd1},
    '{32'd2,          1'b1, 30'd1,          30'd2},
    '{32'd3,          1'b1, 30'd2,          30'd4},
    '{32'd10,         1'b1, 30'd55,         30'd143},
    '{32'd45,         1'b0, 30'd0,          30'd0},
    '{32'hFFFF_FFFF,  1'b0, 30'd0,          30'd0},
    '{32'h8000_0000,  1'b0, 30'd0,          30'd0},
    '{32'h7FFF_FFFF,  1'b0, 30'd0,          30'd0},
    '{32'h5555_5555,  1'b0, 30'd0,          30'd0},
    '{32'hAAAA_AAAA,  1'b0, 30'd0,          30'd0},
    '{32'd1000000008, 1'b0, 30'd0,          30'd0},
    '{32'd2000000014, 1'b1, 30'd1000000006, 30'd1000000006},
    '{32'd2000000015, 1'b1, 30'd1,          30'd0},
    '{32'd2000000016, 1'b1, 30'd0,          30'd0},
    '{32'd4000000032, 1'b1, 30'd0,          30'd0}
  };

  fibonacci_matrix_power_mod_unit uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_index      (in_index),
    .out_strobe    (out_strobe),
    .out_fib_value (out_fib_value),
    .out_prefix_sum(out_prefix_sum)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [63:0] mul_mod_prime(input logic [63:0] a, input logic [63:0] b);
    return (a * b) % PRIME;
  endfunction

  function automatic mat2_t mat2_product(input mat2_t x, input mat2_t y);
    mat2_t r;
    r[0] = (mul_mod_prime(x[0], y[0]) + mul_mod_prime(x[1], y[2])) % PRIME;
    r[1] = (mul_mod_prime(x[0], y[1]) + mul_mod_prime(x[1], y[3])) % PRIME;
    r[2] = (mul_mod_prime(x[2], y[0]) + mul_mod_prime(x[3], y[2])) % PRIME;
    r[3] = (mul_mod_prime(x[2], y[1]) + mul_mod_prime(x[3], y[3])) % PRIME;
    return r;
  endfunction

  // Raises [[0,1],[1,1]] to the index by square-and-multiply. The power holds
  // F(n) in e01 and F(n+1) in e11, so the prefix sum is F(n)+F(n+1)-1.
  function automatic fib_expect_t fib_of_index(input logic [IDX_W-1:0] index);
    mat2_t acc;
    mat2_t base;
    logic [63:0] k;
    logic [63:0] fib_plus2;
    fib_expect_t r;
    acc = {64'd1, 64'd0, 64'd0, 64'd1};
    base = {64'd1, 64'd1, 64'd1, 64'd0};
    k = {32'd0, index} & ((64'd1 << INDEX_BITS) - 64'd1);
    while (k != 64'd0) begin
      if (k[0]) begin
        acc = mat2_product(acc, base);
      end
      base = mat2_product(base, base);
      k = k >> 1;
    end
    fib_plus2 = (acc[1] + acc[3]) % PRIME;
    r.index = index;
    r.fib_value = VAL_W'(acc[1]);
    r.prefix_sum = VAL_W'((fib_plus2 + PRIME - 64'd1) % PRIME);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [IDX_W-1:0] index,
                                 input logic [VAL_W-1:0] got, input logic [VAL_W-1:0] want);
    $display("MISMATCH at %0t: %s, index %0d, got %0d, expected %0d",
             $realtime, what, index, got, want);
    mismatch_count++;
  endtask

  // Drives one item and holds it until the unit takes it. Start stays high
  // when the next item follows at once; it drops only for an idle gap.
  task automatic issue_index(input logic [IDX_W-1:0] index, input bit typed,
                             input logic [VAL_W-1:0] fib, input logic [VAL_W-1:0] pre,
                             input int unsigned gap);
    fib_expect_t want;
    start <= 1'b1;
    in_index <= index;
    do @(posedge clk); while (busy);
    if (typed) begin
      want = '{index, fib, pre};
    end else begin
      want = fib_of_index(index);
    end
    pending_fibs.push_back(want);
    items_sent++;
    if (gap != 0) begin
      start <= 1'b0;
      in_index <= $urandom;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Every strobe is taken at the edge that ends its cycle and matched
  // against the oldest pending result.
  always @(posedge clk) begin : check_results
    fib_expect_t want;
    if (rst_n && out_strobe) begin
      if (pending_fibs.size() == 0) begin
        report_mismatch("result with nothing pending", '0, out_fib_value, '0);
      end else begin
        want = pending_fibs.pop_front();
        results_checked++;
        if (out_fib_value !== want.fib_value) begin
          report_mismatch("fib_value", want.index, out_fib_value, want.fib_value);
        end
        if (out_prefix_sum !== want.prefix_sum) begin
          report_mismatch("prefix_sum", want.index, out_prefix_sum, want.prefix_sum);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results pending",
               cycle_count, pending_fibs.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : drive_items
    logic [IDX_W-1:0] index;
    int unsigned gap;
    int unsigned len;
    bit quiet;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 16) : 0;
      issue_index(directed_rows[i].index, directed_rows[i].typed,
                  directed_rows[i].fib_value, directed_rows[i].prefix_sum, gap);
    end

    // Random part: full-width indices, short indices that finish quickly,
    // indices of random bit length, and indices near the zero residues.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      case ($urandom_range(0, 3))
        0: index = $urandom;
        1: index = $urandom_range(0, 100);
        2: begin
          len = $urandom_range(1, 32);
          index = $urandom >> (32 - len);
        end
        default: index = ZERO_STEP * $urandom_range(1, 4) + $urandom_range(0, 4) - 32'd2;
      endcase
      // A stretch in the middle and the tail of the run go without idling.
      quiet = (i >= 200 && i < 260) || (i >= RANDOM_ITEMS - 60);
      gap = (quiet || $urandom_range(0, 3) != 0) ? 0 : $urandom_range(1, 16);
      issue_index(index, 1'b0, '0, '0, gap);
    end
    start <= 1'b0;

    while (pending_fibs.size() != 0) @(posedge clk);
    repeat (MAX_LATENCY) @(posedge clk);

    $display("Sent %0d indices (%0d directed, rest random), compared %0d results.",
             items_sent, N_DIRECTED, results_checked);
    $display("Mismatches: %0d", mismatch_count);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
